// File: rtl/sensor_frame_receiver_crc16_macros.svh
// ----------------------------------------------------------------------------
// sensor frame receiver assertion macros
// shared wrappers for the concurrent checks on the receiver ports
// ----------------------------------------------------------------------------
`ifndef SENSOR_FRAME_RECEIVER_CRC16_MACROS_SVH
`define SENSOR_FRAME_RECEIVER_CRC16_MACROS_SVH

// check that is switched off while reset is asserted
`define SFR_ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// check that also runs through reset
`define SFR_ASSERT_ANY(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// File: rtl/sfr_pkg.sv
// ----------------------------------------------------------------------------
// sfr_pkg
// types, constants and the crc step shared by the sensor frame receiver
// ----------------------------------------------------------------------------
`default_nettype none

package sfr_pkg;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ADDRESS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COMMAND_CODE     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_FRAME_LENGTH = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_FRAME_LENGTH = 2'd3;

    // configuration reset values
    localparam logic [7:0] RST_DEVICE_ADDRESS   = 8'h01;
    localparam logic [7:0] RST_COMMAND_CODE     = 8'h41;
    localparam logic [7:0] RST_MIN_FRAME_LENGTH = 8'd54;
    localparam logic [7:0] RST_MAX_FRAME_LENGTH = 8'd66;

    // frame length = count * FRAME_LEN_MUL + FRAME_LEN_BASE
    localparam logic [10:0] FRAME_LEN_MUL  = 11'd6;
    localparam logic [10:0] FRAME_LEN_BASE = 11'd12;
    localparam logic [7:0]  COUNT_POSITION = 8'd2;
    localparam logic [7:0]  FIRST_BODY_POS = 8'd3;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_ADDR,
        PH_COUNT,
        PH_FRAME
    } t_phase;

    // what the back end does with a queued byte
    typedef enum logic [1:0] {
        K_START,
        K_DATA,
        K_HOLD,
        K_LAST
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
        logic [7:0] position;
        logic [7:0] addr;
    } t_qentry;

    // one byte through the reflected crc-16
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// File: rtl/sfr_front.sv
// ----------------------------------------------------------------------------
// sfr_front
// header hunt, length check and byte classification, plus config registers
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_front (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [sfr_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [7:0]                      i_cfg_data,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire logic [7:0]                      i_rx_byte,
    input  wire logic                            i_q_full,
    output logic                                 o_q_push,
    output sfr_pkg::t_qentry                     o_q_entry
);
    import sfr_pkg::*;

    logic [7:0] r_dev_addr;
    logic [7:0] r_cmd_code;
    logic [7:0] r_min_len;
    logic [7:0] r_max_len;

    t_phase     r_phase, n_phase;
    logic [7:0] r_pos, n_pos;
    logic [7:0] r_exp_len, n_exp_len;

    logic        accept;
    logic [10:0] frame_len;
    logic [8:0]  pos_plus2;
    logic        len_ok;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = i_q_full;
    assign accept      = i_in_valid && !i_q_full;

    assign frame_len = ({3'b000, i_rx_byte} * FRAME_LEN_MUL) + FRAME_LEN_BASE;
    assign len_ok    = (frame_len >= {3'b000, r_min_len}) && (frame_len <= {3'b000, r_max_len});
    assign pos_plus2 = {1'b0, r_pos} + 9'd2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_addr <= RST_DEVICE_ADDRESS;
            r_cmd_code <= RST_COMMAND_CODE;
            r_min_len  <= RST_MIN_FRAME_LENGTH;
            r_max_len  <= RST_MAX_FRAME_LENGTH;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_DEVICE_ADDRESS:   r_dev_addr <= i_cfg_data;
                CFG_COMMAND_CODE:     r_cmd_code <= i_cfg_data;
                CFG_MIN_FRAME_LENGTH: r_min_len  <= i_cfg_data;
                CFG_MAX_FRAME_LENGTH: r_max_len  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_pos     <= 8'd0;
            r_exp_len <= 8'd0;
        end else begin
            r_phase   <= n_phase;
            r_pos     <= n_pos;
            r_exp_len <= n_exp_len;
        end
    end

    always_comb begin
        n_phase            = r_phase;
        n_pos              = r_pos;
        n_exp_len          = r_exp_len;
        o_q_push           = 1'b0;
        o_q_entry.kind     = K_DATA;
        o_q_entry.data     = i_rx_byte;
        o_q_entry.position = r_pos;
        o_q_entry.addr     = r_dev_addr;
        if (accept) begin
            case (r_phase)
                PH_IDLE: begin
                    if (i_rx_byte == r_dev_addr) begin
                        n_phase = PH_ADDR;
                    end
                end
                PH_ADDR: begin
                    if (i_rx_byte == r_cmd_code) begin
                        // back end seeds its crc over address and command
                        o_q_push       = 1'b1;
                        o_q_entry.kind = K_START;
                        n_phase        = PH_COUNT;
                    end else if (i_rx_byte != r_dev_addr) begin
                        n_phase = PH_IDLE;
                    end
                end
                PH_COUNT: begin
                    if (len_ok) begin
                        o_q_push           = 1'b1;
                        o_q_entry.position = COUNT_POSITION;
                        n_exp_len          = frame_len[7:0];
                        n_pos              = FIRST_BODY_POS;
                        n_phase            = PH_FRAME;
                    end else begin
                        // hunt resumes at the count byte itself
                        n_pos   = 8'd0;
                        n_phase = (i_rx_byte == r_dev_addr) ? PH_ADDR : PH_IDLE;
                    end
                end
                PH_FRAME: begin
                    o_q_push = 1'b1;
                    if (pos_plus2 < {1'b0, r_exp_len}) begin
                        n_pos = r_pos + 8'd1;
                    end else if (pos_plus2 == {1'b0, r_exp_len}) begin
                        o_q_entry.kind = K_HOLD;
                        n_pos          = r_pos + 8'd1;
                    end else begin
                        o_q_entry.kind = K_LAST;
                        n_pos          = 8'd0;
                        n_phase        = PH_IDLE;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// File: rtl/sfr_queue.sv
// ----------------------------------------------------------------------------
// sfr_queue
// short register queue between the front and back ends
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  sfr_pkg::t_qentry       i_entry,
    output logic                   o_full,
    input  wire logic              i_pop,
    output logic                   o_empty,
    output sfr_pkg::t_qentry       o_entry
);
    import sfr_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_qentry          r_slot [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_entry = r_slot[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

// File: rtl/sfr_back.sv
// ----------------------------------------------------------------------------
// sfr_back
// crc-16 over frame bytes, trailer compare and the output register
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_q_empty,
    input  sfr_pkg::t_qentry       i_q_entry,
    output logic                   o_q_pop,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic [7:0]             o_data_byte,
    output logic [7:0]             o_byte_position,
    output logic                   o_last_byte,
    output logic                   o_frame_good
);
    import sfr_pkg::*;

    logic [15:0] r_crc, n_crc;
    logic [7:0]  r_held_low, n_held_low;
    logic        r_seed_half, n_seed_half;

    logic        r_out_valid, n_out_valid;
    logic [7:0]  r_data, n_data;
    logic [7:0]  r_pos, n_pos;
    logic        r_last, n_last;
    logic        r_good, n_good;

    logic        slot_free;
    logic [15:0] crc_step_in;
    logic [15:0] crc_step_out;

    assign slot_free    = !r_out_valid || !i_out_stall;
    // header seeding starts from the init value, all else from the running crc
    assign crc_step_in  = (i_q_entry.kind == K_START && !r_seed_half) ? CRC_INIT : r_crc;
    assign crc_step_out = crc_byte(crc_step_in,
                                   (i_q_entry.kind == K_START && !r_seed_half) ?
                                   i_q_entry.addr : i_q_entry.data);

    always_comb begin
        n_crc       = r_crc;
        n_held_low  = r_held_low;
        n_seed_half = r_seed_half;
        n_out_valid = r_out_valid && i_out_stall;
        n_data      = r_data;
        n_pos       = r_pos;
        n_last      = r_last;
        n_good      = r_good;
        o_q_pop     = 1'b0;
        if (!i_q_empty) begin
            case (i_q_entry.kind)
                K_START: begin
                    // address byte first, then command byte; the entry pops with the command byte
                    n_crc = crc_step_out;
                    if (r_seed_half) begin
                        n_seed_half = 1'b0;
                        o_q_pop     = 1'b1;
                    end else begin
                        n_seed_half = 1'b1;
                    end
                end
                K_DATA, K_HOLD, K_LAST: begin
                    if (slot_free) begin
                        o_q_pop     = 1'b1;
                        n_out_valid = 1'b1;
                        n_data      = i_q_entry.data;
                        n_pos       = i_q_entry.position;
                        n_last      = 1'b0;
                        n_good      = 1'b0;
                        if (i_q_entry.kind == K_DATA) begin
                            n_crc = crc_step_out;
                        end else if (i_q_entry.kind == K_HOLD) begin
                            n_held_low = i_q_entry.data;
                        end else begin
                            n_last = 1'b1;
                            n_good = ({i_q_entry.data, r_held_low} == r_crc);
                            n_crc  = CRC_INIT;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc       <= CRC_INIT;
            r_held_low  <= 8'd0;
            r_seed_half <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_crc       <= n_crc;
            r_held_low  <= n_held_low;
            r_seed_half <= n_seed_half;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        r_pos  <= n_pos;
        r_last <= n_last;
        r_good <= n_good;
    end

    assign o_out_valid     = r_out_valid;
    assign o_data_byte     = r_data;
    assign o_byte_position = r_pos;
    assign o_last_byte     = r_last;
    assign o_frame_good    = r_good;

endmodule

`default_nettype wire

// File: rtl/sensor_frame_receiver_crc16.sv
// ----------------------------------------------------------------------------
// sensor_frame_receiver_crc16
// detection frame receiver: header hunt, length check and crc-16 trailer check
// ----------------------------------------------------------------------------
// input channel: one received byte per transfer (i_in_valid / o_in_stall).
// output channel: frame bytes from the count byte on, with their position,
// a last flag and, on the last byte, the crc result (o_out_valid / i_out_stall).
// config channel: index and data, always ready; it must be written while the
// block idles, which the block itself does not enforce.
// throughput: one byte per cycle while the output does not stall; the crc unit
// seeds over address and command in two steps on a header's command byte. the
// queue absorbs that, so bytes are taken back to back. path: a taken byte
// passes the queue, then the output register; entries waiting ahead of it and
// the header seed ahead of the count byte delay its result.
// header bytes, hunt bytes and rejected count bytes give no transfer.
// when the receiver stalls, the output register holds and the queue fills;
// o_in_stall rises once the queue is full.
// reset: config returns to address 0x01, command 0x41, length 54..66,
// the hunt goes idle and the queue and output register empty.
// ----------------------------------------------------------------------------
`default_nettype none

module sensor_frame_receiver_crc16 #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [sfr_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [7:0]                      i_cfg_data,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire logic [7:0]                      i_rx_byte,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output logic [7:0]                           o_data_byte,
    output logic [7:0]                           o_byte_position,
    output logic                                 o_last_byte,
    output logic                                 o_frame_good
);
    import sfr_pkg::*;

    logic    q_push;
    logic    q_full;
    logic    q_pop;
    logic    q_empty;
    t_qentry q_wr_entry;
    t_qentry q_rd_entry;

    sfr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_rx_byte   (i_rx_byte),
        .i_q_full    (q_full),
        .o_q_push    (q_push),
        .o_q_entry   (q_wr_entry)
    );

    sfr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_wr_entry),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_entry (q_rd_entry)
    );

    sfr_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_empty       (q_empty),
        .i_q_entry       (q_rd_entry),
        .o_q_pop         (q_pop),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_data_byte     (o_data_byte),
        .o_byte_position (o_byte_position),
        .o_last_byte     (o_last_byte),
        .o_frame_good    (o_frame_good)
    );

endmodule

`default_nettype wire

// File: rtl/sfr_checker.sv
// ----------------------------------------------------------------------------
// sfr_checker
// port level checks on the sensor frame receiver, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "sensor_frame_receiver_crc16_macros.svh"

module sfr_checker (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_valid,
    input  wire logic                            o_cfg_ready,
    input  wire logic [sfr_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [7:0]                      i_cfg_data,
    input  wire logic                            i_in_valid,
    input  wire logic                            o_in_stall,
    input  wire logic [7:0]                      i_rx_byte,
    input  wire logic                            o_out_valid,
    input  wire logic                            i_out_stall,
    input  wire logic [7:0]                      o_data_byte,
    input  wire logic [7:0]                      o_byte_position,
    input  wire logic                            o_last_byte,
    input  wire logic                            o_frame_good
);

    // a stalled result stays offered
    `SFR_ASSERT_CLK(a_out_hold, o_out_valid && i_out_stall |=> o_out_valid, "result dropped under stall")

    // crc verdict only on the final byte
    `SFR_ASSERT_CLK(a_good_on_last, o_out_valid && !o_last_byte |-> !o_frame_good, "frame_good set before last byte")

    // header positions never leave the block
    `SFR_ASSERT_CLK(a_pos_min, o_out_valid |-> o_byte_position >= 8'd2, "header position on output")

    // shortest frame is twelve bytes, so its last byte sits at eleven or later
    `SFR_ASSERT_CLK(a_last_pos, o_out_valid && o_last_byte |-> o_byte_position >= 8'd11, "last byte too early")

    // output empties out of reset
    `SFR_ASSERT_ANY(a_rst_empty, !i_rst_n |=> !o_out_valid, "output valid after reset")

endmodule

bind sensor_frame_receiver_crc16 sfr_checker u_checker (.*);

`default_nettype wire

// File: test/tb_sensor_frame_receiver_crc16.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sensor_frame_receiver_crc16
// feeds byte streams through the frame receiver and checks every output
// transfer against an in-bench tracker of the header hunt, length window and
// crc-16 trailer; runs through several address, command and length settings,
// in all but the last with random idle bursts on both channels
// ----------------------------------------------------------------------------

module tb_sensor_frame_receiver_crc16;

    import sfr_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 20;

    typedef struct {
        logic [7:0] data;
        logic [7:0] position;
        logic       last;
        logic       good;
    } t_frame_out;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [7:0]           i_cfg_data = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic [7:0]           i_rx_byte = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [7:0]           o_data_byte;
    logic [7:0]           o_byte_position;
    logic                 o_last_byte;
    logic                 o_frame_good;

    // tracker copy of the register file
    logic [7:0] cfg_addr = RST_DEVICE_ADDRESS;
    logic [7:0] cfg_cmd  = RST_COMMAND_CODE;
    logic [7:0] cfg_min  = RST_MIN_FRAME_LENGTH;
    logic [7:0] cfg_max  = RST_MAX_FRAME_LENGTH;

    // tracker copy of the hunt and frame state
    t_phase      hunt = PH_IDLE;
    logic [15:0] run_crc = CRC_INIT;
    logic [7:0]  frame_pos = '0;
    logic [7:0]  frame_len = '0;
    logic [7:0]  crc_low_byte = '0;

    logic [7:0]  rx_stream[$];
    t_frame_out  frame_bytes_due[$];
    int unsigned n_queued = 0;
    int          n_errors = 0;
    int          quiet_cycles = 0;
    bit          idle_on = 1'b1;
    int          in_gap = 0;
    int          in_calm = 0;
    int          out_gap = 0;
    int          out_calm = 0;

    sensor_frame_receiver_crc16 u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_rx_byte       (i_rx_byte),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_data_byte     (o_data_byte),
        .o_byte_position (o_byte_position),
        .o_last_byte     (o_last_byte),
        .o_frame_good    (o_frame_good)
    );

    always #4 i_clk = ~i_clk;

    // bit-serial form of the reflected crc-16
    function automatic logic [15:0] crc16_a001(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] r;
        logic        fb;
        r = acc;
        for (int k = 0; k < 8; k++) begin
            fb = r[0] ^ b[k];
            r = r >> 1;
            if (fb) begin
                r = r ^ CRC_POLY;
            end
        end
        return r;
    endfunction

    function automatic void emit_frame_byte(input logic [7:0] b, input logic [7:0] p,
                                            input logic last, input logic good);
        t_frame_out e;
        e.data = b;
        e.position = p;
        e.last = last;
        e.good = good;
        frame_bytes_due.push_back(e);
    endfunction

    function automatic void follow_rx_byte(input logic [7:0] b);
        logic [10:0] len;
        case (hunt)
            PH_IDLE: begin
                if (b == cfg_addr) begin
                    hunt = PH_ADDR;
                end
            end
            PH_ADDR: begin
                // command match wins when address and command are equal
                if (b == cfg_cmd) begin
                    run_crc = crc16_a001(crc16_a001(CRC_INIT, cfg_addr), cfg_cmd);
                    hunt = PH_COUNT;
                end else if (b != cfg_addr) begin
                    hunt = PH_IDLE;
                end
            end
            PH_COUNT: begin
                len = {3'b000, b} * FRAME_LEN_MUL + FRAME_LEN_BASE;
                if (len >= {3'b000, cfg_min} && len <= {3'b000, cfg_max}) begin
                    frame_len = len[7:0];
                    run_crc = crc16_a001(run_crc, b);
                    frame_pos = FIRST_BODY_POS;
                    hunt = PH_FRAME;
                    emit_frame_byte(b, COUNT_POSITION, 1'b0, 1'b0);
                end else begin
                    // rejected count byte may itself start the next header
                    run_crc = CRC_INIT;
                    frame_pos = '0;
                    hunt = (b == cfg_addr) ? PH_ADDR : PH_IDLE;
                end
            end
            default: begin
                if ({1'b0, frame_pos} + 9'd2 < {1'b0, frame_len}) begin
                    run_crc = crc16_a001(run_crc, b);
                    emit_frame_byte(b, frame_pos, 1'b0, 1'b0);
                    frame_pos = frame_pos + 8'd1;
                end else if ({1'b0, frame_pos} + 9'd2 == {1'b0, frame_len}) begin
                    crc_low_byte = b;
                    emit_frame_byte(b, frame_pos, 1'b0, 1'b0);
                    frame_pos = frame_pos + 8'd1;
                end else begin
                    emit_frame_byte(b, frame_pos, 1'b1, {b, crc_low_byte} == run_crc);
                    hunt = PH_IDLE;
                    run_crc = CRC_INIT;
                    frame_pos = '0;
                end
            end
        endcase
    endfunction

    // 0 means no idling this cycle, else length of a new idle burst
    function automatic int burst_len(inout int calm);
        if (!idle_on) begin
            return 0;
        end
        if (calm != 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 63) == 0) begin
            calm = $urandom_range(20, 150);
            return 0;
        end
        return ($urandom_range(0, 5) == 0) ? int'($urandom_range(1, 8)) : 0;
    endfunction

    function automatic void check_field(input string what, input logic [7:0] want_v,
                                        input logic [7:0] got_v);
        if (got_v !== want_v) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want_v, got_v);
            n_errors++;
        end
    endfunction

    // input side: tracker update on each transfer, then next byte or idle
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            follow_rx_byte(i_rx_byte);
        end
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!(i_in_valid && o_in_stall)) begin
            if (in_gap == 0) begin
                in_gap = burst_len(in_calm);
            end
            if (in_gap != 0) begin
                in_gap--;
                i_in_valid <= 1'b0;
            end else if (rx_stream.size() != 0) begin
                i_in_valid <= 1'b1;
                i_rx_byte <= rx_stream.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // output side: compare each transfer, then pick the next stall value
    always @(posedge i_clk) begin
        t_frame_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (frame_bytes_due.size() == 0) begin
                $display("%0t: unexpected output, expected none, got byte %0h at position %0d",
                         $time, o_data_byte, o_byte_position);
                n_errors++;
            end else begin
                want = frame_bytes_due.pop_front();
                check_field("data_byte", want.data, o_data_byte);
                check_field("byte_position", want.position, o_byte_position);
                check_field("last_byte", 8'(want.last), 8'(o_last_byte));
                check_field("frame_good", 8'(want.good), 8'(o_frame_good));
            end
        end
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (out_gap == 0) begin
                out_gap = burst_len(out_calm);
            end
            if (out_gap != 0) begin
                out_gap--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("tb_sensor_frame_receiver_crc16: errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic queue_byte(input logic [7:0] b);
        rx_stream.push_back(b);
        n_queued++;
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (rx_stream.size() != 0 || i_in_valid || frame_bytes_due.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        case (idx)
            CFG_DEVICE_ADDRESS:   cfg_addr = val;
            CFG_COMMAND_CODE:     cfg_cmd = val;
            CFG_MIN_FRAME_LENGTH: cfg_min = val;
            CFG_MAX_FRAME_LENGTH: cfg_max = val;
            default: ;
        endcase
    endtask

    // registers change only with both channels empty and the block settled
    task automatic set_config(input logic [7:0] a, input logic [7:0] c,
                              input logic [7:0] mn, input logic [7:0] mx);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        write_reg(CFG_DEVICE_ADDRESS, a);
        write_reg(CFG_COMMAND_CODE, c);
        write_reg(CFG_MIN_FRAME_LENGTH, mn);
        write_reg(CFG_MAX_FRAME_LENGTH, mx);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // whole frame under the current header, count at most 40
    task automatic push_frame(input logic [7:0] count, input bit corrupt);
        logic [7:0]  bytes[$];
        logic [15:0] c;
        int unsigned len;
        int unsigned k;
        len = count * 6 + 12;
        bytes = '{cfg_addr, cfg_cmd, count};
        for (k = 3; k < len - 2; k++) begin
            bytes.push_back(8'($urandom_range(0, 255)));
        end
        c = CRC_INIT;
        foreach (bytes[i]) begin
            c = crc16_a001(c, bytes[i]);
        end
        bytes.push_back(c[7:0]);
        bytes.push_back(c[15:8]);
        if (corrupt) begin
            k = $urandom_range(3, len - 1);
            bytes[k] = bytes[k] ^ 8'($urandom_range(1, 255));
        end
        foreach (bytes[i]) begin
            queue_byte(bytes[i]);
        end
    endtask

    // count inside the length window if one fits, mostly near its low end; random otherwise
    function automatic logic [7:0] pick_count(output bit fits);
        int lo;
        int hi;
        lo = (cfg_min <= 8'd12) ? 0 : (int'(cfg_min) - 12 + 5) / 6;
        hi = (int'(cfg_max) - 12) / 6;
        fits = (cfg_min <= cfg_max) && (lo <= hi);
        if (!fits) begin
            return 8'($urandom_range(0, 255));
        end
        if ($urandom_range(0, 3) != 0) begin
            return 8'(lo + $urandom_range(0, (hi - lo < 2) ? hi - lo : 2));
        end
        return 8'($urandom_range(lo, hi));
    endfunction

    function automatic logic [7:0] noise_byte();
        case ($urandom_range(0, 3))
            0:       return cfg_addr;
            1:       return cfg_cmd;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic run_random(input int unsigned n);
        int unsigned start;
        int unsigned r;
        logic [7:0]  cnt;
        bit          fits;
        start = n_queued;
        while (n_queued - start < n) begin
            r = $urandom_range(0, 99);
            cnt = pick_count(fits);
            if (r < 72 && fits) begin
                push_frame(cnt, r >= 60);
            end else if (r < 86) begin
                repeat ($urandom_range(1, 6)) queue_byte(noise_byte());
            end else begin
                // header followed by a random count or a frame cut short
                queue_byte(cfg_addr);
                if ($urandom_range(0, 1) == 0) begin
                    queue_byte(cfg_addr);
                end
                queue_byte(cfg_cmd);
                if (r < 94) begin
                    queue_byte(8'($urandom_range(0, 255)));
                end else begin
                    queue_byte(cnt);
                    repeat ($urandom_range(0, 5)) queue_byte(8'($urandom_range(0, 255)));
                end
            end
        end
    endtask

    initial begin
        logic [7:0] mn;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // only count 0 fits, so a count byte of 1 equal to the address is turned away
        set_config(8'h01, 8'h41, 8'd12, 8'd12);
        queue_byte(8'hFF);
        queue_byte(8'h00);
        queue_byte(cfg_addr);
        queue_byte(cfg_addr);
        queue_byte(cfg_cmd);
        queue_byte(cfg_addr);
        push_frame(8'd0, 1'b0);
        push_frame(8'd0, 1'b1);

        set_config(RST_DEVICE_ADDRESS, RST_COMMAND_CODE, RST_MIN_FRAME_LENGTH,
                   RST_MAX_FRAME_LENGTH);
        run_random(350);
        set_config(8'h00, 8'hFF, 8'd12, 8'd255);
        run_random(350);
        set_config(8'hFF, 8'h00, 8'd12, 8'd60);
        run_random(300);
        // address equal to command
        set_config(8'h5A, 8'h5A, 8'd12, 8'd40);
        run_random(300);
        // no count reaches 255 exactly
        set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 8'd255, 8'd255);
        run_random(80);
        // empty window
        set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 8'd200, 8'd100);
        run_random(80);
        mn = 8'($urandom_range(12, 120));
        set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), mn,
                   8'($urandom_range(mn, 255)));
        idle_on = 1'b0;
        run_random(400);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("tb_sensor_frame_receiver_crc16: clean");
        end else begin
            $display("tb_sensor_frame_receiver_crc16: errors");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/sfr_pkg.sv
rtl/sfr_front.sv
rtl/sfr_queue.sv
rtl/sfr_back.sv
rtl/sensor_frame_receiver_crc16.sv
rtl/sfr_checker.sv
test/tb_sensor_frame_receiver_crc16.sv
